[sv/ucal_pkg.sv]
// ----------------------------------------------------------------------------
// ucal_pkg: shared types and constants for the calendar converter
// Divider operation codes, controller/datapath command and status
// structs, and the calendar constant tables.
// ----------------------------------------------------------------------------
package ucal_pkg;

  localparam int unsigned IN_W    = 32;
  localparam int unsigned REM_W   = 17;  // divider remainder, holds 86400 - 1
  localparam int unsigned CNT_W   = 2;   // divider step count, up to 3
  localparam int unsigned DAYS_W  = 16;  // whole days since epoch, < 49711
  localparam int unsigned YEAR_W  = 12;  // true year, 1970..2106

  // reciprocal divider: quotient = (x * recip) >> shift, exact for the
  // operand ranges used here; the remainder is x - quotient * divisor
  localparam int unsigned MUL_W   = 25;  // multiplier operand
  localparam int unsigned RCP_W   = 26;  // reciprocal constant
  localparam int unsigned PROD_W  = MUL_W + RCP_W;
  localparam int unsigned QD_W    = DAYS_W + REM_W;
  localparam int unsigned DAY_PRESHIFT = 7;   // 86400 = 128 * 675
  localparam int unsigned DAY_SHIFT    = 35;
  localparam int unsigned DIV60_SHIFT  = 23;
  localparam int unsigned WEEK_SHIFT   = 19;
  localparam logic [CNT_W-1:0] DIV_STEPS = 2'd3;

  localparam logic [REM_W-1:0] SECS_PER_DAY = 17'd86400;
  localparam logic [REM_W-1:0] SECS_PER_MIN = 17'd60;
  localparam logic [REM_W-1:0] DAYS_PER_WK  = 17'd7;

  localparam logic [YEAR_W-1:0] EPOCH_YEAR = 12'd1970;
  localparam logic [YEAR_W-1:0] BASE_YEAR  = 12'd2000;
  localparam logic [YEAR_W-1:0] LAST_YEAR  = 12'd2099;

  // phase of 1970 within the 4, 100 and 400 year leap cycles
  localparam logic [1:0] EPOCH_MOD4   = 2'd2;
  localparam logic [6:0] EPOCH_MOD100 = 7'd70;
  localparam logic [8:0] EPOCH_MOD400 = 9'd370;

  localparam logic [3:0] MON_DEC = 4'd11;
  localparam logic [3:0] MON_FEB = 4'd1;
  localparam logic [6:0] YEAR_MAX_OUT = 7'd99;

  // thursday is weekday 5 in the sunday=1 numbering; (days + 4) % 7 + 1
  localparam logic [DAYS_W-1:0] WEEK_OFFSET = 16'd4;

  typedef enum logic [1:0] {
    OP_DAY,   // seconds / 86400 -> days, second of day
    OP_SEC,   // second of day / 60 -> minute of day, second
    OP_MIN,   // minute of day / 60 -> hour, minute
    OP_WEEK   // (days + 4) / 7 -> remainder gives weekday
  } div_op_t;

  typedef struct packed {
    logic    input_load;
    logic    div_load;
    div_op_t op;
    logic    div_step;
    logic    year_step;
    logic    month_step;
  } ctl_cmd_t;

  typedef struct packed {
    logic div_last;
    logic year_found;
    logic month_found;
  } ctl_stat_t;

  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] len;
    unique case (m)
      4'd1:                   len = 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
      default:                len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic logic [RCP_W-1:0] div_recip(input div_op_t op);
    logic [RCP_W-1:0] m;
    unique case (op)
      OP_DAY:         m = 26'd50903317;  // ceil(2^35 / 675), operand is seconds >> 7
      OP_SEC, OP_MIN: m = 26'd139811;    // ceil(2^23 / 60)
      OP_WEEK:        m = 26'd74899;     // ceil(2^19 / 7)
      default:        m = 26'd50903317;
    endcase
    return m;
  endfunction

  function automatic logic [REM_W-1:0] div_divisor(input div_op_t op);
    logic [REM_W-1:0] d;
    unique case (op)
      OP_DAY:  d = SECS_PER_DAY;
      OP_SEC:  d = SECS_PER_MIN;
      OP_MIN:  d = SECS_PER_MIN;
      OP_WEEK: d = DAYS_PER_WK;
      default: d = SECS_PER_DAY;
    endcase
    return d;
  endfunction

endpackage

[sv/ucal_dp.sv]
// ----------------------------------------------------------------------------
// ucal_dp: calendar converter datapath
// Shared reciprocal-multiply divider for the constant divisors, year and
// month walkers with leap tracking, and the result field registers.
// ----------------------------------------------------------------------------
module ucal_dp (
  input  logic                     clk,
  input  logic                     rst,
  input  ucal_pkg::ctl_cmd_t       cmd,
  output ucal_pkg::ctl_stat_t      stat,
  input  logic [31:0]              unix_seconds,
  output logic [5:0]               second,
  output logic [5:0]               minute,
  output logic [4:0]               hour,
  output logic [2:0]               weekday,
  output logic [4:0]               day_of_month,
  output logic [3:0]               month,
  output logic [6:0]               year,
  output logic                     year_clamped
);

  // divider
  logic [31:0]                      dividend;
  logic [ucal_pkg::CNT_W-1:0]       step_cnt;
  ucal_pkg::div_op_t                op;
  logic [ucal_pkg::REM_W-1:0]       divisor;
  logic [ucal_pkg::RCP_W-1:0]       recip;
  logic [ucal_pkg::MUL_W-1:0]       mul_x;
  logic [ucal_pkg::PROD_W-1:0]      prod;
  logic [ucal_pkg::DAYS_W-1:0]      quo_est;
  logic [ucal_pkg::QD_W-1:0]        qd;
  logic [31:0]                      rem_full;
  logic [ucal_pkg::REM_W-1:0]       rem_val;

  // intermediate fields
  logic [ucal_pkg::DAYS_W-1:0]      days;
  logic [ucal_pkg::REM_W-1:0]       sod;
  logic [10:0]                      mod;
  logic [ucal_pkg::DAYS_W-1:0]      rem_days;

  // year walk
  logic [ucal_pkg::YEAR_W-1:0]      yr;
  logic [1:0]                       c4;
  logic [6:0]                       c100;
  logic [8:0]                       c400;
  logic                             leap;
  logic [8:0]                       year_len;
  logic [4:0]                       mon_len;
  logic [3:0]                       mon;

  logic [31:0]                      load_val;
  logic [ucal_pkg::DAYS_W-1:0]      week_in;

  // step 1: prod = x * recip; step 2: quotient and quotient * divisor;
  // step 3: remainder and field write
  assign divisor  = ucal_pkg::div_divisor(op);
  assign recip    = ucal_pkg::div_recip(op);
  assign mul_x    = (op == ucal_pkg::OP_DAY) ? dividend[31:ucal_pkg::DAY_PRESHIFT]
                                             : dividend[ucal_pkg::MUL_W-1:0];

  always_comb begin
    unique case (op)
      ucal_pkg::OP_DAY:  quo_est = prod[ucal_pkg::DAY_SHIFT +: ucal_pkg::DAYS_W];
      ucal_pkg::OP_SEC,
      ucal_pkg::OP_MIN:  quo_est = prod[ucal_pkg::DIV60_SHIFT +: ucal_pkg::DAYS_W];
      ucal_pkg::OP_WEEK: quo_est = prod[ucal_pkg::WEEK_SHIFT +: ucal_pkg::DAYS_W];
      default:           quo_est = prod[ucal_pkg::DAY_SHIFT +: ucal_pkg::DAYS_W];
    endcase
  end

  assign rem_full = dividend - qd[31:0];
  assign rem_val  = rem_full[ucal_pkg::REM_W-1:0];

  assign week_in = days + ucal_pkg::WEEK_OFFSET;

  // operands are right aligned
  always_comb begin
    unique case (cmd.op)
      ucal_pkg::OP_DAY:  load_val = unix_seconds;
      ucal_pkg::OP_SEC:  load_val = {15'd0, sod};
      ucal_pkg::OP_MIN:  load_val = {21'd0, mod};
      ucal_pkg::OP_WEEK: load_val = {16'd0, week_in};
      default:           load_val = unix_seconds;
    endcase
  end

  assign leap     = (c4 == 2'd0) && ((c100 != 7'd0) || (c400 == 9'd0));
  assign year_len = 9'd365 + {8'd0, leap};
  assign mon_len  = ucal_pkg::month_len(mon) + {4'd0, leap && (mon == ucal_pkg::MON_FEB)};

  assign stat.div_last    = (step_cnt == 2'd1);
  assign stat.year_found  = (rem_days < {7'd0, year_len});
  assign stat.month_found = (rem_days < {11'd0, mon_len}) || (mon == ucal_pkg::MON_DEC);

  always_ff @(posedge clk) begin
    if (rst) begin
      step_cnt <= '0;
    end else if (cmd.div_load) begin
      step_cnt <= ucal_pkg::DIV_STEPS;
    end else if (cmd.div_step) begin
      step_cnt <= step_cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      dividend <= load_val;
      op       <= cmd.op;
    end else if (cmd.div_step) begin
      prod <= {{(ucal_pkg::PROD_W - ucal_pkg::MUL_W){1'b0}}, mul_x}
            * {{(ucal_pkg::PROD_W - ucal_pkg::RCP_W){1'b0}}, recip};
      qd   <= {{(ucal_pkg::QD_W - ucal_pkg::DAYS_W){1'b0}}, quo_est}
            * {{(ucal_pkg::QD_W - ucal_pkg::REM_W){1'b0}}, divisor};
      if (step_cnt == 2'd1) begin
        unique case (op)
          ucal_pkg::OP_DAY: begin
            days     <= quo_est;
            rem_days <= quo_est;
            sod      <= rem_val;
          end
          ucal_pkg::OP_SEC: begin
            mod    <= quo_est[10:0];
            second <= rem_val[5:0];
          end
          ucal_pkg::OP_MIN: begin
            hour   <= quo_est[4:0];
            minute <= rem_val[5:0];
          end
          ucal_pkg::OP_WEEK: begin
            weekday <= rem_val[2:0] + 3'd1;
          end
          default: ;
        endcase
      end
    end

    if (cmd.input_load) begin
      yr   <= ucal_pkg::EPOCH_YEAR;
      c4   <= ucal_pkg::EPOCH_MOD4;
      c100 <= ucal_pkg::EPOCH_MOD100;
      c400 <= ucal_pkg::EPOCH_MOD400;
      mon  <= '0;
    end else if (cmd.year_step && !stat.year_found) begin
      rem_days <= rem_days - {7'd0, year_len};
      yr       <= yr + 12'd1;
      c4       <= c4 + 2'd1;
      c100     <= (c100 == 7'd99)  ? 7'd0 : c100 + 7'd1;
      c400     <= (c400 == 9'd399) ? 9'd0 : c400 + 9'd1;
    end else if (cmd.month_step && !stat.month_found) begin
      rem_days <= rem_days - {11'd0, mon_len};
      mon      <= mon + 4'd1;
    end
  end

  assign day_of_month = rem_days[4:0] + 5'd1;
  assign month        = mon + 4'd1;

  always_comb begin
    priority if (yr < ucal_pkg::BASE_YEAR) begin
      year         = '0;
      year_clamped = 1'b1;
    end else if (yr > ucal_pkg::LAST_YEAR) begin
      year         = ucal_pkg::YEAR_MAX_OUT;
      year_clamped = 1'b1;
    end else begin
      year         = 7'(yr - ucal_pkg::BASE_YEAR);
      year_clamped = 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_step_has_work: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> (step_cnt != 2'd0))
    else $error("divider stepped with no steps left");

  a_rem_in_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.div_step && (step_cnt == 2'd1)) |-> (rem_val < divisor))
    else $error("divider remainder not below divisor");

  a_month_bounded: assert property (@(posedge clk) disable iff (rst)
    cmd.month_step |-> (mon <= ucal_pkg::MON_DEC))
    else $error("month walk ran past december");
`endif

endmodule

[sv/ucal_ctrl.sv]
// ----------------------------------------------------------------------------
// ucal_ctrl: calendar converter controller
// Sequences the four divider passes, the year walk and the month walk,
// and raises the result strobe.
// ----------------------------------------------------------------------------
module ucal_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  output logic                  done,
  output ucal_pkg::ctl_cmd_t    cmd,
  input  ucal_pkg::ctl_stat_t   stat
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_DIV,
    S_YEAR,
    S_MONTH
  } state_t;

  state_t            state;
  ucal_pkg::div_op_t op;
  ucal_pkg::div_op_t op_next;
  logic              accept;

  assign accept = (state == S_IDLE) && start;

  always_comb begin
    unique case (op)
      ucal_pkg::OP_DAY:  op_next = ucal_pkg::OP_SEC;
      ucal_pkg::OP_SEC:  op_next = ucal_pkg::OP_MIN;
      ucal_pkg::OP_MIN:  op_next = ucal_pkg::OP_WEEK;
      ucal_pkg::OP_WEEK: op_next = ucal_pkg::OP_DAY;
      default:           op_next = ucal_pkg::OP_DAY;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.op         = (state == S_IDLE) ? ucal_pkg::OP_DAY : op;
    cmd.input_load = accept;
    cmd.div_load   = accept || (state == S_LOAD);
    cmd.div_step   = (state == S_DIV);
    cmd.year_step  = (state == S_YEAR);
    cmd.month_step = (state == S_MONTH);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op    <= ucal_pkg::OP_DAY;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_DIV;
            op    <= ucal_pkg::OP_DAY;
            busy  <= 1'b1;
          end
        end
        S_LOAD: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (stat.div_last) begin
            op <= op_next;
            if (op == ucal_pkg::OP_WEEK) begin
              state <= S_YEAR;
            end else begin
              state <= S_LOAD;
            end
          end
        end
        S_YEAR: begin
          if (stat.year_found) begin
            state <= S_MONTH;
          end
        end
        S_MONTH: begin
          if (stat.month_found) begin
            state <= S_IDLE;
            busy  <= 1'b0;
            done  <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_busy_tracks_state: assert property (@(posedge clk) disable iff (rst)
    busy == (state != S_IDLE))
    else $error("busy disagrees with controller state");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held longer than one cycle");

  a_done_after_month: assert property (@(posedge clk) disable iff (rst)
    $rose(done) |-> $past(state == S_MONTH))
    else $error("result strobe without finishing the month walk");
`endif

endmodule

[sv/unix_time_to_calendar.sv]
// ----------------------------------------------------------------------------
// unix_time_to_calendar: seconds-since-1970 to calendar date and time
// Top level: joins the controller and the datapath.
// ----------------------------------------------------------------------------
// Usage:
//   Drive unix_seconds and raise start. A transaction is accepted at the
//   rising edge where start is high and busy is low; busy then stays high
//   until the conversion completes.
//   The result (second, minute, hour, weekday with Sunday = 1, day_of_month,
//   month, year as year-2000 saturated to 0..99, year_clamped) is shown
//   for exactly one cycle marked by done. The receiver cannot stall; the
//   fields are valid only in that cycle.
// Sequence: four passes through the shared reciprocal divider (days,
//   seconds, minutes, weekday), with a reload step between passes; then
//   the year walk steps through the whole years after 1970 (0..136) and
//   the month walk through the zero-based months (0..11), each walk
//   ending in the step where its target is found. The year walk dominates.
// Throughput: one transaction at a time; busy falls together with done, so
//   the next transaction can be accepted at the edge that ends the done cycle.
// Reset: synchronous rst returns the controller to idle with busy and done
//   low; any conversion in flight is dropped.
// ----------------------------------------------------------------------------
module unix_time_to_calendar (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] unix_seconds,
  output logic        done,
  output logic [5:0]  second,
  output logic [5:0]  minute,
  output logic [4:0]  hour,
  output logic [2:0]  weekday,
  output logic [4:0]  day_of_month,
  output logic [3:0]  month,
  output logic [6:0]  year,
  output logic        year_clamped
);

  // command and status between controller and datapath
  ucal_pkg::ctl_cmd_t  cmd;
  ucal_pkg::ctl_stat_t stat;

  ucal_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd),
    .stat  (stat)
  );

  // fields are held in datapath registers; they change only when the
  // next transaction loads, which is after the done cycle has ended
  ucal_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .unix_seconds (unix_seconds),
    .second       (second),
    .minute       (minute),
    .hour         (hour),
    .weekday      (weekday),
    .day_of_month (day_of_month),
    .month        (month),
    .year         (year),
    .year_clamped (year_clamped)
  );

endmodule
